@@ sv/sjs_pkg.sv @@
// Shared types and constants of the SRTF job scheduler.
// Used by the controller, the datapath, the top level and the checker.
package sjs_pkg;

    localparam int ID_W            = 22;
    localparam int JOB_TIME_W      = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 16;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_DENY  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SCAN_FIND  = 2'd0,
        SCAN_MIN   = 2'd1,
        SCAN_SHIFT = 2'd2
    } t_scan;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_REQ_TAIL = 3'd1,
        WR_REQ_POS  = 3'd2,
        WR_RUN_TAIL = 3'd3,
        WR_RUN_LAST = 3'd4
    } t_wr;

    typedef struct packed {
        logic    latch_req;
        logic    set_run_req;
        logic    set_run_time;
        logic    clear_run;
        logic    set_run_best;
        logic    scan_init;
        logic    scan_en;
        t_scan   scan_mode;
        t_wr     wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic run_valid;
        logic id_eq_run;
        logic req_zero;
        logic req_lt_run;
        logic count_zero;
        logic full;
        logic found;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/srtf_job_scheduler.sv @@
// Top level of the SRTF job scheduler: controller plus datapath.
// Depends on sjs_pkg, sjs_ctrl and sjs_datapath.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------------
//   request   | i_req_valid / o_req_ready  | i_requester_id, i_job_time
//   response  | o_rsp_valid / i_rsp_ready  | o_status, o_running_valid,
//             |                            | o_running_id, o_running_time
//
// One request is in work at a time. A request from an idle block, or a time update of
// the running job that needs no new pick from the table, is answered without a scan;
// a table search, a minimum search and a compaction pass each read the waiting table
// one entry at a time through its single read port.
// Reset is synchronous and clears the running job and the table fill count.
// The response register holds a finished result while the next request is accepted;
// a stalled response only delays the following one.
module srtf_job_scheduler import sjs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic [ID_W-1:0]       i_requester_id,
    input  logic [JOB_TIME_W-1:0] i_job_time,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output logic [1:0]            o_status,
    output logic                  o_running_valid,
    output logic [ID_W-1:0]       o_running_id,
    output logic [JOB_TIME_W-1:0] o_running_time
);

    localparam int TIME_W = (TIME_BITS < JOB_TIME_W) ? TIME_BITS : JOB_TIME_W;

    t_cmd              w_cmd;
    t_dp_stat          w_stat;
    t_status           w_status;
    logic [TIME_W-1:0] w_run_time;

    sjs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sjs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_W      (TIME_W)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_requester_id  (i_requester_id),
        .i_job_time      (i_job_time[TIME_W-1:0]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_rsp_ready     (i_rsp_ready),
        .o_rsp_valid     (o_rsp_valid),
        .o_status        (w_status),
        .o_running_valid (o_running_valid),
        .o_running_id    (o_running_id),
        .o_running_time  (w_run_time)
    );

    assign o_status       = w_status;
    assign o_running_time = JOB_TIME_W'(w_run_time);

endmodule

@@ sv/sjs_ctrl.sv @@
// Controller state machine of the SRTF job scheduler.
// Depends on sjs_pkg for the command and status structs.
module sjs_ctrl import sjs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_FIND   = 8'b0000_0100,
        S_PLACE  = 8'b0000_1000,
        S_MIN    = 8'b0001_0000,
        S_SHIFT  = 8'b0010_0000,
        S_FIX    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_from_min, n_from_min;
    t_cmd   cmd;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;

    always_comb begin
        cmd        = '0;
        n_state    = r_state;
        n_from_min = r_from_min;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.latch_req = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_GRANT;
                if (!i_stat.run_valid) begin
                    cmd.set_run_req = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.id_eq_run) begin
                    if (!i_stat.req_zero) begin
                        cmd.set_run_time = 1'b1;
                        n_state          = S_DONE;
                    end else if (i_stat.count_zero) begin
                        cmd.clear_run = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        cmd.scan_init = 1'b1;
                        cmd.scan_mode = SCAN_MIN;
                        n_state       = S_MIN;
                    end
                end else begin
                    cmd.scan_init = 1'b1;
                    cmd.scan_mode = SCAN_FIND;
                    n_state       = S_FIND;
                end
            end
            S_FIND: begin
                cmd.scan_en   = 1'b1;
                cmd.scan_mode = SCAN_FIND;
                if (i_stat.found || i_stat.scan_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.set_status = 1'b1;
                n_state        = S_DONE;
                if (!i_stat.found && i_stat.full) begin
                    cmd.status = ST_FULL;
                end else if (i_stat.req_lt_run && !i_stat.found) begin
                    // The new requester preempts at once; the old job goes to the tail.
                    cmd.status      = ST_GRANT;
                    cmd.wr_sel      = WR_RUN_TAIL;
                    cmd.cnt_inc     = 1'b1;
                    cmd.set_run_req = 1'b1;
                end else if (i_stat.req_lt_run) begin
                    cmd.status    = ST_GRANT;
                    cmd.scan_init = 1'b1;
                    cmd.scan_mode = SCAN_SHIFT;
                    n_from_min    = 1'b0;
                    n_state       = S_SHIFT;
                end else if (!i_stat.found) begin
                    cmd.status  = ST_DENY;
                    cmd.wr_sel  = WR_REQ_TAIL;
                    cmd.cnt_inc = 1'b1;
                end else begin
                    cmd.status = ST_DENY;
                    cmd.wr_sel = WR_REQ_POS;
                end
            end
            S_MIN: begin
                cmd.scan_en   = 1'b1;
                cmd.scan_mode = SCAN_MIN;
                if (i_stat.scan_done) begin
                    cmd.scan_en   = 1'b0;
                    cmd.scan_init = 1'b1;
                    cmd.scan_mode = SCAN_SHIFT;
                    n_from_min    = 1'b1;
                    n_state       = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.scan_en   = 1'b1;
                cmd.scan_mode = SCAN_SHIFT;
                if (i_stat.scan_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_DONE;
                if (r_from_min) begin
                    cmd.cnt_dec      = 1'b1;
                    cmd.set_run_best = 1'b1;
                end else begin
                    // The table kept its size: the old job fills the freed last slot.
                    cmd.wr_sel      = WR_RUN_LAST;
                    cmd.set_run_req = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_from_min <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_from_min <= n_from_min;
        end
    end

endmodule

@@ sv/sjs_datapath.sv @@
// Datapath of the SRTF job scheduler: waiting-table memory, scan unit,
// running job and result register. Depends on sjs_pkg.
module sjs_datapath import sjs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_W      = DEF_TIME_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ID_W-1:0]   i_requester_id,
    input  logic [TIME_W-1:0] i_job_time,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output t_status           o_status,
    output logic              o_running_valid,
    output logic [ID_W-1:0]   o_running_id,
    output logic [TIME_W-1:0] o_running_time
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_W-1:0]   mem_id   [QUEUE_DEPTH];
    logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];

    logic [ID_W-1:0]   r_rd_id;
    logic [TIME_W-1:0] r_rd_time;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_pidx;
    logic              r_pv;
    logic              r_found;
    logic [CW-1:0]     r_pos;
    logic [ID_W-1:0]   r_best_id;
    logic [TIME_W-1:0] r_best_time;
    logic [ID_W-1:0]   r_req_id;
    logic [TIME_W-1:0] r_req_time;
    logic              r_run_valid;
    logic [ID_W-1:0]   r_run_id;
    logic [TIME_W-1:0] r_run_time;
    t_status           r_status;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_run_valid;
    logic [ID_W-1:0]   r_out_run_id;
    logic [TIME_W-1:0] r_out_run_time;

    logic              issue;
    logic              hit;
    logic              better;
    logic              we;
    logic [AW-1:0]     wa;
    logic [ID_W-1:0]   wd_id;
    logic [TIME_W-1:0] wd_time;
    logic [CW-1:0]     pidx_m1;
    logic [CW-1:0]     count_m1;

    assign pidx_m1  = r_pidx - CW'(1);
    assign count_m1 = r_count - CW'(1);

    // One table read per cycle; the compare runs on the registered read data in the next cycle.
    assign issue  = i_cmd.scan_en && (r_idx != r_count)
                    && !((i_cmd.scan_mode == SCAN_FIND) && r_found);
    assign hit    = i_cmd.scan_en && (i_cmd.scan_mode == SCAN_FIND) && r_pv && !r_found
                    && (r_rd_id == r_req_id);
    assign better = i_cmd.scan_en && (i_cmd.scan_mode == SCAN_MIN) && r_pv
                    && ((r_pidx == '0) || (r_rd_time < r_best_time));

    always_comb begin
        we      = 1'b0;
        wa      = '0;
        wd_id   = r_req_id;
        wd_time = r_req_time;
        if (i_cmd.scan_en && (i_cmd.scan_mode == SCAN_SHIFT) && r_pv) begin
            // Compaction: each entry above the removed one moves down by one slot.
            we      = 1'b1;
            wa      = pidx_m1[AW-1:0];
            wd_id   = r_rd_id;
            wd_time = r_rd_time;
        end else begin
            unique case (i_cmd.wr_sel)
                WR_NONE: begin
                    we = 1'b0;
                end
                WR_REQ_TAIL: begin
                    we = 1'b1;
                    wa = r_count[AW-1:0];
                end
                WR_REQ_POS: begin
                    we = 1'b1;
                    wa = r_pos[AW-1:0];
                end
                WR_RUN_TAIL: begin
                    we      = 1'b1;
                    wa      = r_count[AW-1:0];
                    wd_id   = r_run_id;
                    wd_time = r_run_time;
                end
                WR_RUN_LAST: begin
                    we      = 1'b1;
                    wa      = count_m1[AW-1:0];
                    wd_id   = r_run_id;
                    wd_time = r_run_time;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_id[wa]   <= wd_id;
            mem_time[wa] <= wd_time;
        end
        if (issue) begin
            r_rd_id   <= mem_id[r_idx[AW-1:0]];
            r_rd_time <= mem_time[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_pidx  <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_cmd.scan_init) begin
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= (i_cmd.scan_mode == SCAN_SHIFT) ? (r_pos + CW'(1)) : '0;
        end else if (i_cmd.scan_en) begin
            r_pv   <= issue;
            r_pidx <= r_idx;
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= r_pidx;
            end
            if (better) begin
                r_pos <= r_pidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (better) begin
            r_best_id   <= r_rd_id;
            r_best_time <= r_rd_time;
        end
        if (i_cmd.latch_req) begin
            r_req_id   <= i_requester_id;
            r_req_time <= i_job_time;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status    <= r_status;
            r_out_run_valid <= r_run_valid;
            r_out_run_id    <= r_run_id;
            r_out_run_time  <= r_run_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_time  <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= count_m1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.set_run_req) begin
                r_run_valid <= 1'b1;
                r_run_id    <= r_req_id;
                r_run_time  <= r_req_time;
            end else if (i_cmd.set_run_time) begin
                r_run_time <= r_req_time;
            end else if (i_cmd.clear_run) begin
                r_run_valid <= 1'b0;
                r_run_id    <= '0;
                r_run_time  <= '0;
            end else if (i_cmd.set_run_best) begin
                r_run_id   <= r_best_id;
                r_run_time <= r_best_time;
            end
        end
    end

    always_comb begin
        o_stat.run_valid  = r_run_valid;
        o_stat.id_eq_run  = (r_req_id == r_run_id);
        o_stat.req_zero   = (r_req_time == '0);
        o_stat.req_lt_run = (r_req_time < r_run_time);
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
        o_stat.found      = r_found;
        o_stat.scan_done  = (r_idx == r_count) && !r_pv;
        o_stat.out_free   = !r_out_valid || i_rsp_ready;
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_running_valid = r_out_run_valid;
    assign o_running_id    = r_out_run_id;
    assign o_running_time  = r_out_run_time;

endmodule

@@ sv/sjs_checker.sv @@
// Port-level checker of the SRTF job scheduler, bound to the top level.
// Depends on sjs_pkg for the status codes.
module sjs_port_checks import sjs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  o_req_ready,
    input logic [ID_W-1:0]       i_requester_id,
    input logic [JOB_TIME_W-1:0] i_job_time,
    input logic                  o_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [1:0]            o_status,
    input logic                  o_running_valid,
    input logic [ID_W-1:0]       o_running_id,
    input logic [JOB_TIME_W-1:0] o_running_time
);

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another one is in work");

    // An idle block reports a cleared running job.
    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_running_valid) |-> (o_running_id == '0 && o_running_time == '0))
        else $error("idle response carries a stale running job");

    // A full waiting table can only exist next to a running job.
    a_full_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status == ST_FULL) |-> o_running_valid)
        else $error("table-full status without a running job");

    // A stalled response keeps its status, running id and running time.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=>
            (o_rsp_valid && $stable(o_status) && $stable(o_running_id)
             && $stable(o_running_time)))
        else $error("stalled response changed");

endmodule

bind srtf_job_scheduler sjs_port_checks u_sjs_checker (.*);

@@ test/sjs_checker.sv @@
// Checker for the SRTF job scheduler: watches both channels, predicts each response
// from its own model of the running job and the waiting table, and compares field by field.
// Depends on sjs_pkg.
module sjs_checker import sjs_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [ID_W-1:0]       i_requester_id,
    input  logic [JOB_TIME_W-1:0] i_job_time,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  logic [1:0]            i_status,
    input  logic                  i_running_valid,
    input  logic [ID_W-1:0]       i_running_id,
    input  logic [JOB_TIME_W-1:0] i_running_time,
    output int                    o_fail_count,
    output int                    o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [JOB_TIME_W-1:0] TIME_MASK =
        (TIME_BITS >= JOB_TIME_W) ? {JOB_TIME_W{1'b1}} : JOB_TIME_W'((1 << TIME_BITS) - 1);

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [JOB_TIME_W-1:0] jt;
    } t_wait_entry;

    typedef struct packed {
        t_status               status;
        logic                  running_valid;
        logic [ID_W-1:0]       running_id;
        logic [JOB_TIME_W-1:0] running_time;
    } t_sched_rsp;

    logic                  run_valid;
    logic [ID_W-1:0]       run_id;
    logic [JOB_TIME_W-1:0] run_jt;
    t_wait_entry           wait_tbl[$];
    t_sched_rsp            sched_rsp_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        run_valid    = 1'b0;
        run_id       = '0;
        run_jt       = '0;
    end

    // Applies one request to the model state and returns the response it must produce.
    function automatic t_sched_rsp predict_response(input logic [ID_W-1:0] id,
                                                    input logic [JOB_TIME_W-1:0] jt_in);
        t_sched_rsp            r;
        t_wait_entry           ent;
        logic [JOB_TIME_W-1:0] jt;
        int                    best;
        int                    pos;
        jt       = jt_in & TIME_MASK;
        r.status = ST_GRANT;
        if (!run_valid) begin
            run_valid = 1'b1;
            run_id    = id;
            run_jt    = jt;
        end else if (id == run_id) begin
            run_jt = jt;
            if (jt == '0) begin
                if (wait_tbl.size() == 0) begin
                    run_valid = 1'b0;
                    run_id    = '0;
                    run_jt    = '0;
                end else begin
                    // Strict less-than keeps the earliest queued entry on a tie.
                    best = 0;
                    for (int i = 1; i < wait_tbl.size(); i++) begin
                        if (wait_tbl[i].jt < wait_tbl[best].jt) best = i;
                    end
                    run_id = wait_tbl[best].id;
                    run_jt = wait_tbl[best].jt;
                    wait_tbl.delete(best);
                end
            end
        end else begin
            pos = -1;
            for (int i = 0; i < wait_tbl.size(); i++) begin
                if (pos < 0 && wait_tbl[i].id == id) pos = i;
            end
            if (pos < 0 && wait_tbl.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (pos < 0) begin
                    ent.id = id;
                    ent.jt = jt;
                    wait_tbl.push_back(ent);
                    pos = wait_tbl.size() - 1;
                end else begin
                    wait_tbl[pos].jt = jt;
                end
                if (jt < run_jt) begin
                    // The requester leaves the table first, so the old job always fits.
                    wait_tbl.delete(pos);
                    ent.id = run_id;
                    ent.jt = run_jt;
                    wait_tbl.push_back(ent);
                    run_id = id;
                    run_jt = jt;
                end else begin
                    r.status = ST_DENY;
                end
            end
        end
        r.running_valid = run_valid;
        r.running_id    = run_id;
        r.running_time  = run_jt;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sched_rsp want;
        if (!i_rst_n) begin
            run_valid = 1'b0;
            run_id    = '0;
            run_jt    = '0;
            wait_tbl.delete();
            sched_rsp_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (sched_rsp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = sched_rsp_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_running_valid !== want.running_valid) begin
                        $error("running_valid: expected %0d, got %0d",
                               want.running_valid, i_running_valid);
                        o_fail_count++;
                    end
                    if (i_running_id !== want.running_id) begin
                        $error("running_id: expected 0x%06h, got 0x%06h",
                               want.running_id, i_running_id);
                        o_fail_count++;
                    end
                    if (i_running_time !== want.running_time) begin
                        $error("running_time: expected 0x%04h, got 0x%04h",
                               want.running_time, i_running_time);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                sched_rsp_q.push_back(predict_response(i_requester_id, i_job_time));
            end
        end
        o_pending = sched_rsp_q.size();
    end

endmodule

@@ test/tb.sv @@
// Testbench top for the SRTF job scheduler: clock, reset, request stimulus and
// response back-pressure. Depends on sjs_pkg, srtf_job_scheduler and sjs_checker.
module tb;

    import sjs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM       = 1750;
    localparam int POOL_SIZE      = 24;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * DEF_QUEUE_DEPTH + 32;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_req_valid    = 1'b0;
    logic [ID_W-1:0]       i_requester_id = '0;
    logic [JOB_TIME_W-1:0] i_job_time     = '0;
    logic                  i_rsp_ready    = 1'b0;
    logic                  o_req_ready;
    logic                  o_rsp_valid;
    logic [1:0]            o_status;
    logic                  o_running_valid;
    logic [ID_W-1:0]       o_running_id;
    logic [JOB_TIME_W-1:0] o_running_time;

    int                    fail_count;
    int                    pending;
    int                    rsp_seen      = 0;
    int                    quiet_cycles  = 0;
    logic                  seen_run_valid = 1'b0;
    logic [ID_W-1:0]       seen_run_id    = '0;
    logic [ID_W-1:0]       id_pool[POOL_SIZE];

    always #1 i_clk = ~i_clk;

    srtf_job_scheduler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_requester_id  (i_requester_id),
        .i_job_time      (i_job_time),
        .o_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .o_status        (o_status),
        .o_running_valid (o_running_valid),
        .o_running_id    (o_running_id),
        .o_running_time  (o_running_time)
    );

    sjs_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .i_req_ready     (o_req_ready),
        .i_requester_id  (i_requester_id),
        .i_job_time      (i_job_time),
        .i_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .i_status        (o_status),
        .i_running_valid (o_running_valid),
        .i_running_id    (o_running_id),
        .i_running_time  (o_running_time),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Track the running job as last reported, so stimulus can aim updates and ends at it.
    always @(posedge i_clk) begin
        if (o_rsp_valid && i_rsp_ready) begin
            rsp_seen++;
            seen_run_valid <= o_running_valid;
            seen_run_id    <= o_running_id;
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no request or response accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic put_request(input logic [ID_W-1:0] id, input logic [JOB_TIME_W-1:0] jt);
        i_req_valid    <= 1'b1;
        i_requester_id <= id;
        i_job_time     <= jt;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    function automatic logic [JOB_TIME_W-1:0] pick_job_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return JOB_TIME_W'($urandom);
            default: return JOB_TIME_W'($urandom_range(1, 24));
        endcase
    endfunction

    // Receiver: stalls in stretches of varying shape, with one long hold-off
    // that lets the block fill up and stop taking requests.
    initial begin : rsp_side
        int unsigned mode;
        int unsigned len;
        bit          held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && rsp_seen >= 300) begin
                held = 1'b1;
                i_rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            len  = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0:       i_rsp_ready <= 1'b1;
                    1:       i_rsp_ready <= 1'b0;
                    2:       i_rsp_ready <= 1'($urandom_range(0, 1));
                    default: i_rsp_ready <= 1'(k & 1);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int                    sent;
        int                    burst;
        int                    gap;
        int                    pool_lim;
        logic [ID_W-1:0]       id;
        logic [JOB_TIME_W-1:0] jt;
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
        id_pool[0] = '0;
        id_pool[1] = '1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero time on an idle block, then that job ends with an empty table.
        put_request(22'h000000, 16'h0000);
        put_request(22'h000000, 16'h0000);
        put_request(22'h3FFFFF, 16'hFFFF);
        // Equal time is denied; lower time preempts.
        put_request(22'h000001, 16'hFFFF);
        put_request(22'h000002, 16'h0005);
        put_request(22'h000001, 16'h0005);
        put_request(22'h000004, 16'h0009);
        put_request(22'h000002, 16'h0009);
        put_request(22'h000005, 16'h0005);
        // Job ends pick the least time, earliest queued on ties.
        put_request(22'h000005, 16'h0000);
        put_request(22'h000001, 16'h0000);
        put_request(22'h000004, 16'h0000);
        put_request(22'h000002, 16'h0000);
        put_request(22'h3FFFFF, 16'h0000);
        put_request(22'h2AAAAA, 16'h5555);
        put_request(22'h155555, 16'hAAAA);
        put_request(22'h155555, 16'h1234);

        sent = 0;
        while (sent < N_RANDOM) begin
            // Small pools churn the running job; the full pool overflows the table.
            case ((sent / 250) % 3)
                0:       pool_lim = 4;
                1:       pool_lim = 12;
                default: pool_lim = POOL_SIZE;
            endcase
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                if (seen_run_valid && $urandom_range(0, 9) < 3) begin
                    id = seen_run_id;
                    jt = ($urandom_range(0, 9) < 6) ? '0 : pick_job_time();
                end else if ($urandom_range(0, 19) == 0) begin
                    id = ID_W'($urandom);
                    jt = pick_job_time();
                end else begin
                    id = id_pool[$urandom_range(0, pool_lim - 1)];
                    jt = pick_job_time();
                end
                put_request(id, jt);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_req_valid <= 1'b0;

        // Let the checker log the last request before waiting for its response.
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/sjs_pkg.sv
sv/sjs_ctrl.sv
sv/sjs_datapath.sv
sv/srtf_job_scheduler.sv
sv/sjs_checker.sv
test/sjs_checker.sv
test/tb.sv
